### hw/rtl/sactl_pkg.sv
// Shared constants and codes for the set-associative cache tag lookup block.
package sactl_pkg;

	localparam int LINE_COUNT_DEF   = 2048;
	localparam int ADDRESS_BITS_DEF = 32;

	localparam int WAY_W  = 11;
	localparam int PROD_W = 2 * WAY_W;
	localparam int CFG_W  = 4;
	localparam int IDX_W  = 2;

	localparam logic [3:0] BITS_CAP = 4'd11;

	localparam logic [1:0] OUT_HIT  = 2'd0;
	localparam logic [1:0] OUT_FILL = 2'd1;
	localparam logic [1:0] OUT_REPL = 2'd2;

	localparam logic [IDX_W-1:0] CFG_OFFSET = 2'd0;
	localparam logic [IDX_W-1:0] CFG_SETS   = 2'd1;
	localparam logic [IDX_W-1:0] CFG_WAYS   = 2'd2;

	localparam logic [2:0] OFFSET_RST = 3'd4;
	localparam logic [3:0] SETS_RST   = 4'd8;
	localparam logic [3:0] WAYS_RST   = 4'd3;

endpackage

### hw/rtl/sactl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sactl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/set_assoc_cache_tag_lookup_top.sv
// Tag store and lookup sequencer of a set-associative cache; replacement takes victim_way.
// Sequence: after the accept, a scan issues one tag read a cycle and examines each read,
//   then an update state writes any fill and advances a counter and done is pulsed; a
//   non-power-of-two LINE_COUNT adds a remainder state in front. A hit ends the scan early.
// Throughput: one access at a time, busy high until the update cycle ends; the receiver
//   cannot stall the done strobe. Reset: a clearing pass over every line with busy high.
module set_assoc_cache_tag_lookup_top #(
	parameter int LINE_COUNT   = sactl_pkg::LINE_COUNT_DEF,
	parameter int ADDRESS_BITS = sactl_pkg::ADDRESS_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        cfg_we,
	input  logic [sactl_pkg::IDX_W-1:0] cfg_index,
	input  logic [sactl_pkg::CFG_W-1:0] cfg_data,
	input  logic [31:0]                 address,
	input  logic [10:0]                 victim_way,
	output logic                        done,
	output logic [1:0]                  outcome,
	output logic [10:0]                 way_used,
	output logic [31:0]                 hit_total,
	output logic [31:0]                 miss_total
);

	// Line pointer width, stored tag width.
	localparam int PW   = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
	localparam bit POW2 = (LINE_COUNT & (LINE_COUNT - 1)) == 0;
	localparam int AW   = (ADDRESS_BITS < 32) ? ADDRESS_BITS : 32;
	localparam logic [31:0] AMASK = (AW >= 32) ? 32'hFFFF_FFFF
	                                           : 32'((64'd1 << AW) - 64'd1);
	localparam logic [PW-1:0] LAST_LINE = PW'(LINE_COUNT - 1);
	localparam int W = sactl_pkg::WAY_W;
	localparam int PROD_W = sactl_pkg::PROD_W;

	// Reciprocal of the line count, exact for every set*ways product.
	localparam int LOG_N = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 0;
	localparam int SH    = PROD_W + LOG_N;
	localparam int MW    = PROD_W + 2;
	localparam int QW    = PROD_W + MW;
	localparam logic [MW-1:0] RECIP =
		MW'(((64'd1 << SH) + 64'(LINE_COUNT) - 64'd1) / 64'(LINE_COUNT));

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_MOD   = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]        state_q;
	logic [2:0]        offset_q;
	logic [3:0]        setb_q;
	logic [3:0]        wayb_q;
	logic [AW-1:0]     tag_q;
	logic [PROD_W-1:0] prod_q;
	logic [PROD_W-1:0] quo_q;
	logic              step_q;
	logic [W-1:0]      last_q;
	logic [W-1:0]      victim_q;
	logic [PW-1:0]     la_q;
	logic [W-1:0]      iw_q;
	logic              iss_done_q;
	logic              rv_q;
	logic [W-1:0]      cw_q;
	logic [PW-1:0]     cl_q;
	logic              have_empty_q;
	logic [W-1:0]      empty_way_q;
	logic [PW-1:0]     empty_line_q;
	logic [PW-1:0]     vic_line_q;
	logic [1:0]        res_outcome_q;
	logic [W-1:0]      res_way_q;
	logic [PW-1:0]     fill_line_q;
	logic [31:0]       hit_cnt_q;
	logic [31:0]       miss_cnt_q;
	logic              done_q;
	logic [1:0]        outcome_q;
	logic [W-1:0]      way_used_q;

	// Address split, done once at accept.
	logic [31:0]       addr_m;
	logic [31:0]       blk;
	logic [3:0]        sb;
	logic [3:0]        wb;
	logic [W-1:0]      set_idx;
	logic [31:0]       tag_full;
	logic [PROD_W-1:0] prod;
	logic [PW-1:0]     base_p2;
	logic [W-1:0]      last_c;

	// Line base remainder and line pointer advance.
	logic [PROD_W-1:0] quo_c;
	logic [PW-1:0]     rem_c;
	logic [PW-1:0]     la_inc;

	// Tag store port.
	logic              ram_we;
	logic [PW-1:0]     ram_waddr;
	logic [AW:0]       ram_wdata;
	logic              ram_re;
	logic [AW:0]       ram_rdata;

	logic              rd_valid;
	logic              is_hit;
	logic              at_last;

	always_comb begin
		addr_m   = address & AMASK;
		blk      = addr_m >> offset_q;
		sb       = (setb_q > sactl_pkg::BITS_CAP) ? sactl_pkg::BITS_CAP : setb_q;
		wb       = (wayb_q > sactl_pkg::BITS_CAP) ? sactl_pkg::BITS_CAP : wayb_q;
		set_idx  = blk[W-1:0] & ~({W{1'b1}} << sb);
		tag_full = blk >> sb;
		prod     = PROD_W'(set_idx) << wb;
		base_p2  = PW'(prod & PROD_W'(LINE_COUNT - 1));
		last_c   = ~({W{1'b1}} << wb);
	end

	// Line base remainder by reciprocal multiply: quotient first,
	// then the remainder.
	always_comb begin
		quo_c  = PROD_W'((QW'(prod_q) * QW'(RECIP)) >> SH);
		rem_c  = PW'(prod_q - PROD_W'(quo_q * PROD_W'(LINE_COUNT)));
		la_inc = (la_q == LAST_LINE) ? '0 : la_q + PW'(1);
	end

	assign rd_valid = ram_rdata[AW];
	assign is_hit   = rv_q && rd_valid && (ram_rdata[AW-1:0] == tag_q);
	assign at_last  = cw_q == last_q;

	// The clearing pass and the miss update share the write port.
	assign ram_we    = (state_q == ST_CLEAR) ||
	                   ((state_q == ST_DONE) && (res_outcome_q != sactl_pkg::OUT_HIT));
	assign ram_waddr = (state_q == ST_CLEAR) ? la_q : fill_line_q;
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : {1'b1, tag_q};
	assign ram_re    = (state_q == ST_SCAN) && !iss_done_q;

	sactl_ram #(
		.WIDTH (AW + 1),
		.DEPTH (LINE_COUNT)
	) u_tag_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (la_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			offset_q      <= sactl_pkg::OFFSET_RST;
			setb_q        <= sactl_pkg::SETS_RST;
			wayb_q        <= sactl_pkg::WAYS_RST;
			tag_q         <= '0;
			prod_q        <= '0;
			quo_q         <= '0;
			step_q        <= 1'b0;
			last_q        <= '0;
			victim_q      <= '0;
			la_q          <= '0;
			iw_q          <= '0;
			iss_done_q    <= 1'b0;
			rv_q          <= 1'b0;
			cw_q          <= '0;
			cl_q          <= '0;
			have_empty_q  <= 1'b0;
			empty_way_q   <= '0;
			empty_line_q  <= '0;
			vic_line_q    <= '0;
			res_outcome_q <= sactl_pkg::OUT_HIT;
			res_way_q     <= '0;
			fill_line_q   <= '0;
			hit_cnt_q     <= '0;
			miss_cnt_q    <= '0;
			done_q        <= 1'b0;
			outcome_q     <= sactl_pkg::OUT_HIT;
			way_used_q    <= '0;
		end else begin
			done_q <= 1'b0;

			// Register writes are taken in any state; unknown indexes drop.
			if (cfg_we) begin
				case (cfg_index)
					sactl_pkg::CFG_OFFSET: offset_q <= cfg_data[2:0];
					sactl_pkg::CFG_SETS:   setb_q   <= cfg_data;
					sactl_pkg::CFG_WAYS:   wayb_q   <= cfg_data;
					default: ;
				endcase
			end

			case (state_q)
				ST_CLEAR: begin
					// Sweep every line invalid, one a cycle.
					la_q <= la_inc;
					if (la_q == LAST_LINE) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						tag_q        <= tag_full[AW-1:0];
						prod_q       <= prod;
						step_q       <= 1'b0;
						last_q       <= last_c;
						victim_q     <= victim_way & last_c;
						la_q         <= base_p2;
						iw_q         <= '0;
						iss_done_q   <= 1'b0;
						rv_q         <= 1'b0;
						have_empty_q <= 1'b0;
						state_q      <= POW2 ? ST_SCAN : ST_MOD;
					end
				end
				ST_MOD: begin
					// Hold the quotient, then take the remainder as the line base.
					step_q <= 1'b1;
					if (!step_q) begin
						quo_q <= quo_c;
					end else begin
						la_q    <= rem_c;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// Issue: read one way's line per cycle.
					rv_q <= !iss_done_q;
					if (!iss_done_q) begin
						cw_q <= iw_q;
						cl_q <= la_q;
						if (iw_q == last_q) begin
							iss_done_q <= 1'b1;
						end else begin
							iw_q <= iw_q + W'(1);
							la_q <= la_inc;
						end
					end
					// Examine: the line read in the previous cycle.
					if (rv_q) begin
						if (is_hit) begin
							res_outcome_q <= sactl_pkg::OUT_HIT;
							res_way_q     <= cw_q;
							state_q       <= ST_DONE;
						end else begin
							if (!rd_valid && !have_empty_q) begin
								have_empty_q <= 1'b1;
								empty_way_q  <= cw_q;
								empty_line_q <= cl_q;
							end
							if (cw_q == victim_q) begin
								vic_line_q <= cl_q;
							end
							if (at_last) begin
								state_q <= ST_DONE;
								if (have_empty_q) begin
									res_outcome_q <= sactl_pkg::OUT_FILL;
									res_way_q     <= empty_way_q;
									fill_line_q   <= empty_line_q;
								end else if (!rd_valid) begin
									res_outcome_q <= sactl_pkg::OUT_FILL;
									res_way_q     <= cw_q;
									fill_line_q   <= cl_q;
								end else begin
									res_outcome_q <= sactl_pkg::OUT_REPL;
									res_way_q     <= victim_q;
									fill_line_q   <= (cw_q == victim_q) ? cl_q : vic_line_q;
								end
							end
						end
					end
				end
				ST_DONE: begin
					// On a miss write the fill through the port above; advance a counter, pulse done.
					if (res_outcome_q == sactl_pkg::OUT_HIT) begin
						hit_cnt_q <= hit_cnt_q + 32'd1;
					end else begin
						miss_cnt_q <= miss_cnt_q + 32'd1;
					end
					done_q     <= 1'b1;
					outcome_q  <= res_outcome_q;
					way_used_q <= res_way_q;
					state_q    <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy       = state_q != ST_IDLE;
	assign done       = done_q;
	assign outcome    = outcome_q;
	assign way_used   = way_used_q;
	assign hit_total  = hit_cnt_q;
	assign miss_total = miss_cnt_q;

endmodule

### hw/rtl/sactl_checker.sv
// Port-level checks of the cache tag lookup, bound to its top level.
module sactl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  outcome,
	input logic [31:0] hit_total,
	input logic [31:0] miss_total
);

	// An accepted word holds the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	// A hit advances only the hit count.
	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && (outcome == sactl_pkg::OUT_HIT) |->
		(hit_total == $past(hit_total) + 32'd1) && (miss_total == $past(miss_total)))
		else $error("hit result with wrong counts");

	// A miss advances only the miss count.
	a_miss_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && (outcome == sactl_pkg::OUT_FILL || outcome == sactl_pkg::OUT_REPL) |->
		(miss_total == $past(miss_total) + 32'd1) && (hit_total == $past(hit_total)))
		else $error("miss result with wrong counts");

	// Results carry a known outcome and never come in back-to-back cycles.
	a_done_shape: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (outcome != 2'd3) && !$past(done))
		else $error("malformed result strobe");

endmodule

bind set_assoc_cache_tag_lookup_top sactl_checker u_sactl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.outcome    (outcome),
	.hit_total  (hit_total),
	.miss_total (miss_total)
);

### tb/tb_top.sv
// Self-checking testbench for the set-associative cache tag lookup block.
`timescale 1ns / 100ps

module tb_top;

	localparam int NUM_LINES   = sactl_pkg::LINE_COUNT_DEF;
	localparam int STALL_LIMIT = 16384;  // above the reset clear and a 2048-way scan
	localparam int TAIL_CYCLES = 64;
	localparam int RECENT_MAX  = 64;

	// Index past the last register; the block must drop writes to it.
	localparam logic [sactl_pkg::IDX_W-1:0] CFG_SPARE = 2'd3;

	// One access word as the driver presents it.
	typedef struct {
		logic [31:0] address;
		logic [10:0] victim;
		bit          drain;    // hold this word until every lookup result is back
		int unsigned gap_pct;  // chance of an idle cycle in front of this word
	} access_word_t;

	// What one access should report.
	typedef struct {
		logic [1:0]  outcome;
		logic [10:0] way;
		logic [31:0] hits;
		logic [31:0] misses;
	} lookup_result_t;

	logic                          clk        = 1'b0;
	logic                          arst_n     = 1'b0;
	logic                          start      = 1'b0;
	logic                          busy;
	logic                          cfg_we     = 1'b0;
	logic [sactl_pkg::IDX_W-1:0]   cfg_index  = '0;
	logic [sactl_pkg::CFG_W-1:0]   cfg_data   = '0;
	logic [31:0]                   address    = '0;
	logic [10:0]                   victim_way = '0;
	logic                          done;
	logic [1:0]                    outcome;
	logic [10:0]                   way_used;
	logic [31:0]                   hit_total;
	logic [31:0]                   miss_total;

	// Words waiting to be driven, and lookup results still owed by the block.
	access_word_t   pending_words[$];
	lookup_result_t lookup_results[$];
	logic [31:0]    recent_addrs[$];

	// Shadow of the tag store, the counters and the geometry registers.
	bit        line_ok   [NUM_LINES];
	bit [31:0] line_tags [NUM_LINES];
	bit [31:0] hit_count  = '0;
	bit [31:0] miss_count = '0;
	logic [2:0] cur_offset = sactl_pkg::OFFSET_RST;
	logic [3:0] cur_sets   = sactl_pkg::SETS_RST;
	logic [3:0] cur_ways   = sactl_pkg::WAYS_RST;

	int unsigned    err_count = 0;
	int unsigned    words_taken = 0;
	int unsigned    n_hit = 0, n_fill = 0, n_repl = 0;
	int unsigned    settings_run = 1;
	int unsigned    idle_cycles = 0;
	logic           took_word = 1'b0;
	access_word_t   next_word;
	lookup_result_t want;

	set_assoc_cache_tag_lookup_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.address    (address),
		.victim_way (victim_way),
		.done       (done),
		.outcome    (outcome),
		.way_used   (way_used),
		.hit_total  (hit_total),
		.miss_total (miss_total)
	);

	// 2 ns clock.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic flag_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		err_count++;
	endtask

	// Set and way counts above eleven bits saturate.
	function automatic int capped(input logic [3:0] v);
		return (v > sactl_pkg::BITS_CAP) ? int'(sactl_pkg::BITS_CAP) : int'(v);
	endfunction

	// Look up one access in the shadow store, fill or replace on a miss,
	// and return what the block should report for it.
	function automatic lookup_result_t predict_access(input logic [31:0] addr,
			input logic [10:0] victim);
		int             sb, ways, line;
		bit [31:0]      blk, set_idx, tag;
		bit             hit, have_empty;
		int unsigned    used, empty_way;
		lookup_result_t r;
		sb         = capped(cur_sets);
		ways       = 1 << capped(cur_ways);
		blk        = addr >> cur_offset;
		set_idx    = blk & ((32'd1 << sb) - 32'd1);
		tag        = blk >> sb;
		hit        = 1'b0;
		have_empty = 1'b0;
		used       = 0;
		empty_way  = 0;
		// Lines past the store size wrap around, so ways may alias.
		for (int w = 0; w < ways; w++) begin
			line = (set_idx * ways + w) % NUM_LINES;
			if (!hit && line_ok[line] && line_tags[line] == tag) begin
				hit  = 1'b1;
				used = w;
			end
			if (!hit && !line_ok[line] && !have_empty) begin
				have_empty = 1'b1;
				empty_way  = w;
			end
		end
		if (hit) begin
			hit_count++;
			r.outcome = sactl_pkg::OUT_HIT;
		end else begin
			miss_count++;
			if (have_empty) begin
				used      = empty_way;
				r.outcome = sactl_pkg::OUT_FILL;
			end else begin
				// Full set: the victim choice is masked to the way count.
				used      = victim & (ways - 1);
				r.outcome = sactl_pkg::OUT_REPL;
			end
			line            = (set_idx * ways + used) % NUM_LINES;
			line_ok[line]   = 1'b1;
			line_tags[line] = tag;
		end
		r.way    = used[10:0];
		r.hits   = hit_count;
		r.misses = miss_count;
		return r;
	endfunction

	// Build a random access for the current geometry: mostly addresses that
	// collide in a few sets or revisit recent lines, plus some pure noise.
	function automatic access_word_t make_word(input int unsigned gap);
		access_word_t w;
		int           sb, ways, span;
		int unsigned  pick;
		logic [31:0]  off_mask, tag, set_sel;
		sb       = capped(cur_sets);
		ways     = 1 << capped(cur_ways);
		off_mask = (32'd1 << cur_offset) - 32'd1;
		pick     = $urandom_range(99);
		if (pick < 15) begin
			w.address = $urandom;
		end else if (pick < 50 && recent_addrs.size() != 0) begin
			// Same line, other byte within it.
			w.address = recent_addrs[$urandom_range(recent_addrs.size() - 1)]
			            ^ ($urandom & off_mask);
		end else begin
			span      = ($urandom_range(3) == 0 || sb < 2) ? (1 << sb) : 4;
			tag       = $urandom_range(2 * ways + 1);
			set_sel   = $urandom_range(span - 1);
			w.address = (((tag << sb) | set_sel) << cur_offset) | ($urandom & off_mask);
		end
		recent_addrs.push_back(w.address);
		if (recent_addrs.size() > RECENT_MAX)
			void'(recent_addrs.pop_front());
		w.victim  = $urandom_range(2047);
		w.drain   = ($urandom_range(99) < 3);
		w.gap_pct = gap;
		return w;
	endfunction

	task automatic queue_word(input logic [31:0] addr, input logic [10:0] victim,
			input bit drain);
		access_word_t w;
		w.address = addr;
		w.victim  = victim;
		w.drain   = drain;
		w.gap_pct = 26;
		pending_words.push_back(w);
	endtask

	// Block address layout under the reset geometry: 16-byte lines, 256 sets.
	function automatic logic [31:0] home_addr(input logic [31:0] tag, input logic [31:0] set_sel);
		return (tag << 12) | (set_sel << 4);
	endfunction

	// Wait until the driver is empty and every lookup result is back.
	// Check half a phase after the falling edge so driver updates have landed.
	task automatic wait_idle();
		do begin
			@(negedge clk);
			#0.5;
		end while (pending_words.size() != 0 || start || busy || lookup_results.size() != 0);
	endtask

	task automatic write_reg(input logic [sactl_pkg::IDX_W-1:0] idx,
			input logic [sactl_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			sactl_pkg::CFG_OFFSET: cur_offset = val[2:0];
			sactl_pkg::CFG_SETS:   cur_sets   = val;
			sactl_pkg::CFG_WAYS:   cur_ways   = val;
			default: begin
			end
		endcase
	endtask

	// Change the geometry while idle, then queue a batch of random accesses.
	task automatic run_setting(input logic [sactl_pkg::CFG_W-1:0] offset_val,
			input logic [sactl_pkg::CFG_W-1:0] sets_val,
			input logic [sactl_pkg::CFG_W-1:0] ways_val,
			input int count, input int unsigned gap);
		wait_idle();
		write_reg(sactl_pkg::CFG_OFFSET, offset_val);
		write_reg(sactl_pkg::CFG_SETS, sets_val);
		write_reg(sactl_pkg::CFG_WAYS, ways_val);
		settings_run++;
		repeat (count) pending_words.push_back(make_word(gap));
	endtask

	// Driver: advance to the next word once the current one is taken or start
	// is low; hold start and the payload while the block is busy.
	always @(negedge clk) begin
		if (arst_n && (!start || took_word)) begin
			if (pending_words.size() != 0
			    && $urandom_range(99) >= pending_words[0].gap_pct
			    && !(pending_words[0].drain && lookup_results.size() != 0)) begin
				next_word = pending_words.pop_front();
				start      <= 1'b1;
				address    <= next_word.address;
				victim_way <= next_word.victim;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: check each strobed result against the oldest lookup result,
	// then predict for any word taken on this edge.
	always @(posedge clk) begin
		took_word <= start && !busy;
		if (arst_n && done) begin
			if (lookup_results.size() == 0) begin
				flag_error($sformatf("result with no access pending: outcome %0d way %0d",
					outcome, way_used));
			end else begin
				want = lookup_results.pop_front();
				if (outcome !== want.outcome)
					flag_error($sformatf("outcome %0d, want %0d", outcome, want.outcome));
				if (way_used !== want.way)
					flag_error($sformatf("way_used %0d, want %0d", way_used, want.way));
				if (hit_total !== want.hits)
					flag_error($sformatf("hit_total %0d, want %0d", hit_total, want.hits));
				if (miss_total !== want.misses)
					flag_error($sformatf("miss_total %0d, want %0d", miss_total, want.misses));
				case (want.outcome)
					sactl_pkg::OUT_HIT:  n_hit++;
					sactl_pkg::OUT_FILL: n_fill++;
					default:             n_repl++;
				endcase
			end
		end
		if (arst_n && start && !busy) begin
			lookup_results.push_back(predict_access(address, victim_way));
			words_taken++;
		end
	end

	// Watchdog: drop the run if nothing moves for too long.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("TIMEOUT: no word moved for %0d cycles", STALL_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// Directed accesses under the reset geometry (16-byte lines, 256 sets, 8 ways).
		queue_word(32'h0000_0000, 11'd0, 1'b1);          // cold miss into way 0
		queue_word(32'h0000_000F, 11'd0, 1'b0);          // last byte of the same line hits
		queue_word(32'hFFFF_FFFF, 11'd2047, 1'b0);       // top address, last set
		queue_word(32'hFFFF_FFF0, 11'd0, 1'b0);          // hit on the top line
		for (int t = 1; t < 8; t++)
			queue_word(home_addr(t, 0), 11'd0, 1'b0);    // fill set 0 completely
		queue_word(home_addr(8, 0), 11'd2047, 1'b0);     // full set, victim masked to way 7
		queue_word(home_addr(9, 0), 11'd0, 1'b0);        // replace way 0
		queue_word(home_addr(0, 0), 11'h555, 1'b0);      // evicted tag misses again
		queue_word(home_addr(10, 0), 11'h2AA, 1'b0);
		queue_word(home_addr(8, 0) | 32'h7, 11'd0, 1'b0);
		queue_word(home_addr(9, 0), 11'd0, 1'b0);
		queue_word(home_addr(32'h80000, 32'h80), 11'd1, 1'b0);
		queue_word(32'h8000_0000, 11'h400, 1'b0);
		queue_word(32'h7FFF_FFFF, 11'd3, 1'b0);
		queue_word(32'h0000_0010, 11'd0, 1'b1);          // neighbor set, after a drain
		repeat (400) pending_words.push_back(make_word(26));

		// Fully associative, byte lines, 16 ways.
		run_setting(4'd0, 4'd0, 4'd4, 300, 26);
		// Direct mapped with the widest offset and set fields.
		run_setting(4'd7, 4'd11, 4'd0, 300, 63);
		// Oversized fields: offset wraps to 5, set count saturates and lines alias.
		run_setting(4'd13, 4'd15, 4'd1, 200, 63);
		// 64 sets of 64 ways overlap in the store.
		run_setting(4'd3, 4'd6, 4'd6, 200, 0);
		// One set of 2048 ways: slow scans, so keep it short.
		run_setting(4'd1, 4'd0, 4'd15, 30, 0);
		// Back to the reset geometry; the spare index must not disturb it.
		run_setting(4'd4, 4'd8, 4'd3, 0, 0);
		write_reg(CFG_SPARE, 4'd1);
		repeat (120) pending_words.push_back(make_word(0));

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (lookup_results.size() != 0)
			flag_error($sformatf("%0d lookup results never arrived", lookup_results.size()));
		$display("Covered %0d accesses over %0d cache geometries", words_taken, settings_run);
		$display("Outcomes: %0d hits, %0d fills, %0d replacements", n_hit, n_fill, n_repl);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
